// File: rtl/sfrc_pkg.sv
`timescale 1ns / 1ps

package sfrc_pkg;

	localparam logic [7:0] START_BYTE  = 8'h0F;
	localparam logic [7:0] END_BYTE    = 8'h04;
	localparam logic [7:0] ESCAPE_BYTE = 8'h05;
	localparam logic [15:0] CRC_INIT   = 16'hFFFF;

	typedef enum logic [2:0] {
		MODE_HUNT1   = 3'd0,
		MODE_HUNT2   = 3'd1,
		MODE_COLLECT = 3'd2,
		MODE_ESCAPE  = 3'd3,
		MODE_HALT    = 3'd4
	} rx_mode_t;

	typedef enum logic [2:0] {
		ST_OK               = 3'd0,
		ST_BAD_CRC          = 3'd1,
		ST_UNEXPECTED_START = 3'd2,
		ST_OVERRUN          = 3'd3,
		ST_TOO_SHORT        = 3'd4
	} status_t;

	typedef enum logic {
		KIND_BYTE   = 1'b0,
		KIND_REPORT = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] byte_index;
		logic [7:0] byte_value;
		status_t    status;
		logic [7:0] payload_len;
	} result_t;

	// crc-16/ccitt, poly 0x1021, msb first, one byte
	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = {crc[7:0], crc[15:8]};
		c = c ^ {8'h00, b};
		c = c ^ {12'h000, c[7:4]};
		c = c ^ {c[3:0], 12'h000};
		c = c ^ {3'b000, c[7:0], 5'b00000};
		return c;
	endfunction

endpackage

// File: rtl/stuffed_frame_receiver_crc16.sv
`timescale 1ns / 1ps

// channel  dir  tdata                                      tuser
// s_axis   in   [7:0] rx_byte                              -
// m_axis   out  [7:0] byte_index, [15:8] byte_value,       [0] kind
//               [18:16] status, [26:19] payload_len
//
// one byte per cycle sustained while the output does not stall; an input transfer reaches the
// result through the input register, then the mode/crc logic into the result register
// reset: hunting the first start byte, count zero, crc 0xffff, no result held
// a held result stalls input only when the next byte also gives a result
// after any error report the block takes bytes and ignores them until reset

module stuffed_frame_receiver_crc16 #(
	parameter int BUFFER_BYTES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // byte_index, byte_value, status, payload_len, zero pad
	output logic        m_tuser    // kind
);

	localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
	localparam int EXT_W = (CNT_W > 8) ? CNT_W : 8;

	logic                valid_s1;
	logic [7:0]          byte_s1;
	sfrc_pkg::rx_mode_t  mode_q, mode_d;
	logic [CNT_W-1:0]    count_q, count_d;
	logic [15:0]         crc_q, crc_d;
	sfrc_pkg::result_t   res_q, res_d;
	logic                out_valid_q;
	logic                res_valid;
	logic                fire;
	logic                do_store, do_end, overrun;
	logic [EXT_W-1:0]    count_ext, plen_ext;

	assign count_ext = EXT_W'(count_q);
	assign plen_ext  = count_ext - EXT_W'(2);

	// decode shared by next state and result
	always_comb begin
		do_store = 1'b0;
		do_end   = 1'b0;
		case (mode_q)
			sfrc_pkg::MODE_COLLECT: begin
				do_end   = (byte_s1 == sfrc_pkg::END_BYTE);
				do_store = (byte_s1 != sfrc_pkg::END_BYTE) &&
				           (byte_s1 != sfrc_pkg::START_BYTE) &&
				           (byte_s1 != sfrc_pkg::ESCAPE_BYTE);
			end
			sfrc_pkg::MODE_ESCAPE: begin
				do_store = 1'b1;
			end
			default: begin
				do_store = 1'b0;
			end
		endcase
		overrun = do_store && (count_q == CNT_W'(BUFFER_BYTES));
	end

	// next state
	always_comb begin
		mode_d  = mode_q;
		count_d = count_q;
		crc_d   = crc_q;
		case (mode_q)
			sfrc_pkg::MODE_HUNT1: begin
				if (byte_s1 == sfrc_pkg::START_BYTE) begin
					mode_d = sfrc_pkg::MODE_HUNT2;
				end
			end
			sfrc_pkg::MODE_HUNT2: begin
				if (byte_s1 == sfrc_pkg::START_BYTE) begin
					mode_d  = sfrc_pkg::MODE_COLLECT;
					count_d = '0;
					crc_d   = sfrc_pkg::CRC_INIT;
				end else begin
					mode_d = sfrc_pkg::MODE_HUNT1;
				end
			end
			sfrc_pkg::MODE_COLLECT, sfrc_pkg::MODE_ESCAPE: begin
				if (do_store) begin
					if (overrun) begin
						mode_d = sfrc_pkg::MODE_HALT;
					end else begin
						mode_d  = sfrc_pkg::MODE_COLLECT;
						count_d = count_q + CNT_W'(1);
						crc_d   = sfrc_pkg::crc_update(crc_q, byte_s1);
					end
				end else if (do_end) begin
					if (count_q == CNT_W'(1)) begin
						mode_d = sfrc_pkg::MODE_HALT;
					end else if (count_q > CNT_W'(2) && crc_q != 16'h0000) begin
						mode_d = sfrc_pkg::MODE_HALT;
					end else begin
						mode_d = sfrc_pkg::MODE_HUNT1;
					end
				end else if (byte_s1 == sfrc_pkg::ESCAPE_BYTE) begin
					mode_d = sfrc_pkg::MODE_ESCAPE;
				end else begin
					mode_d = sfrc_pkg::MODE_HALT;
				end
			end
			default: begin
				mode_d = sfrc_pkg::MODE_HALT;
			end
		endcase
	end

	// result
	always_comb begin
		res_valid         = 1'b0;
		res_d.kind        = sfrc_pkg::KIND_REPORT;
		res_d.byte_index  = 8'h00;
		res_d.byte_value  = 8'h00;
		res_d.status      = sfrc_pkg::ST_OK;
		res_d.payload_len = 8'h00;
		if (do_store) begin
			res_valid = 1'b1;
			if (overrun) begin
				res_d.status = sfrc_pkg::ST_OVERRUN;
			end else begin
				res_d.kind       = sfrc_pkg::KIND_BYTE;
				res_d.byte_index = count_ext[7:0];
				res_d.byte_value = byte_s1;
			end
		end else if (do_end) begin
			res_valid = 1'b1;
			if (count_q == CNT_W'(1)) begin
				res_d.status = sfrc_pkg::ST_TOO_SHORT;
			end else if (count_q != '0) begin
				res_d.payload_len = plen_ext[7:0];
				if (count_q > CNT_W'(2) && crc_q != 16'h0000) begin
					res_d.status = sfrc_pkg::ST_BAD_CRC;
				end
			end
		end else if (mode_q == sfrc_pkg::MODE_COLLECT &&
		             byte_s1 == sfrc_pkg::START_BYTE) begin
			res_valid    = 1'b1;
			res_d.status = sfrc_pkg::ST_UNEXPECTED_START;
		end
	end

	assign fire     = valid_s1 && (!res_valid || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			mode_q      <= sfrc_pkg::MODE_HUNT1;
			count_q     <= '0;
			crc_q       <= sfrc_pkg::CRC_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (fire) begin
				mode_q  <= mode_d;
				count_q <= count_d;
				crc_q   <= crc_d;
			end
			if (fire && res_valid) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
		if (fire && res_valid) begin
			res_q <= res_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = res_q.kind;
	assign m_tdata  = {5'b00000, res_q.payload_len, res_q.status,
	                   res_q.byte_value, res_q.byte_index};

	a_halt_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == sfrc_pkg::MODE_HALT |=> mode_q == sfrc_pkg::MODE_HALT)
		else $error("left halted mode without reset");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(BUFFER_BYTES))
		else $error("stored count beyond buffer size");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res_valid |-> !out_valid_q || m_tready)
		else $error("held result overwritten");

	a_byte_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.kind == sfrc_pkg::KIND_BYTE |->
		res_q.status == sfrc_pkg::ST_OK && res_q.payload_len == 8'h00)
		else $error("stored byte carries report fields");

endmodule

// File: verif/sfrc_frame_checker.sv
`timescale 1ns / 1ps

package sfrc_tb_pkg;

	// bitwise crc-16/ccitt, msb first
	function automatic logic [15:0] crc16_ccitt_byte(input logic [15:0] c, input logic [7:0] d);
		logic [15:0] r;
		r = c ^ {d, 8'h00};
		for (int i = 0; i < 8; i++)
			r = r[15] ? ({r[14:0], 1'b0} ^ 16'h1021) : {r[14:0], 1'b0};
		return r;
	endfunction

endpackage

module sfrc_frame_checker #(
	parameter int BUFFER_BYTES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic        m_tuser,
	output int          errors,
	output int          pending
);

	import sfrc_pkg::*;
	import sfrc_tb_pkg::*;

	rx_mode_t    mode;
	int          stored;
	logic [15:0] crc;
	result_t     expected_q[$];

	function automatic result_t store_frame_byte(input logic [7:0] b);
		result_t r;
		r = '0;
		if (stored >= BUFFER_BYTES) begin
			mode = MODE_HALT;
			r.kind = KIND_REPORT;
			r.status = ST_OVERRUN;
		end else begin
			r.kind = KIND_BYTE;
			r.byte_index = 8'(stored);
			r.byte_value = b;
			crc = crc16_ccitt_byte(crc, b);
			stored++;
			mode = MODE_COLLECT;
		end
		return r;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t %s: expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : track
		result_t r;
		result_t want;
		bit      emits;
		if (!arst_n) begin
			mode = MODE_HUNT1;
			stored = 0;
			crc = CRC_INIT;
			expected_q.delete();
		end else begin
			if (s_tvalid && s_tready) begin
				emits = 1'b0;
				r = '0;
				case (mode)
				MODE_HUNT1: begin
					if (s_tdata == START_BYTE)
						mode = MODE_HUNT2;
				end
				MODE_HUNT2: begin
					if (s_tdata == START_BYTE) begin
						mode = MODE_COLLECT;
						stored = 0;
						crc = CRC_INIT;
					end else begin
						mode = MODE_HUNT1;
					end
				end
				MODE_COLLECT: begin
					emits = 1'b1;
					if (s_tdata == ESCAPE_BYTE) begin
						mode = MODE_ESCAPE;
						emits = 1'b0;
					end else if (s_tdata == START_BYTE) begin
						mode = MODE_HALT;
						r.kind = KIND_REPORT;
						r.status = ST_UNEXPECTED_START;
					end else if (s_tdata == END_BYTE) begin
						r.kind = KIND_REPORT;
						mode = MODE_HUNT1;
						if (stored == 1) begin
							mode = MODE_HALT;
							r.status = ST_TOO_SHORT;
						end else if (stored > 1) begin
							r.payload_len = 8'(stored - 2);
							// empty payload skips the residue check
							if (stored > 2 && crc != 16'h0000) begin
								mode = MODE_HALT;
								r.status = ST_BAD_CRC;
							end
						end
					end else begin
						r = store_frame_byte(s_tdata);
					end
				end
				MODE_ESCAPE: begin
					emits = 1'b1;
					r = store_frame_byte(s_tdata);
				end
				default: begin
					mode = MODE_HALT;
				end
				endcase
				if (emits)
					expected_q.push_back(r);
			end
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					$display("%0t unexpected result: expected none, actual kind %0b tdata %0h",
						$time, m_tuser, m_tdata);
					errors++;
				end else begin
					want = expected_q.pop_front();
					check_field("kind", int'(want.kind), int'(m_tuser));
					check_field("byte_index", int'(want.byte_index), int'(m_tdata[7:0]));
					check_field("byte_value", int'(want.byte_value), int'(m_tdata[15:8]));
					check_field("status", int'(want.status), int'(m_tdata[18:16]));
					check_field("payload_len", int'(want.payload_len), int'(m_tdata[26:19]));
				end
			end
		end
		pending <= expected_q.size();
	end

endmodule

// File: verif/tb_stuffed_frame_receiver_crc16.sv
`timescale 1ns / 1ps

module tb_stuffed_frame_receiver_crc16;

	import sfrc_pkg::*;
	import sfrc_tb_pkg::*;

	localparam int BUFFER_BYTES = 256;
	localparam int ITEMS        = 2000;
	localparam int STALL_LIMIT  = 2000;
	localparam int HOLD_AT      = 400;
	localparam int HOLD_OFF     = 300;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tuser;

	int errors;
	int pending;
	int frame_bytes;
	int results_seen;
	int idle_cycles;
	int send_idle_max;
	int recv_idle_max;

	always #2 clk = ~clk;

	stuffed_frame_receiver_crc16 #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	sfrc_frame_checker #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.errors(errors),
		.pending(pending)
	);

	function automatic logic [7:0] rand_frame_byte();
		int pick;
		pick = $urandom_range(0, 7);
		if (pick == 0)
			return START_BYTE;
		if (pick == 1)
			return END_BYTE;
		if (pick == 2)
			return ESCAPE_BYTE;
		return 8'($urandom);
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = $urandom_range(0, send_idle_max);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata  <= b;
		s_tvalid <= 1'b1;
		frame_bytes++;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// control bytes must be escaped, others now and then
	task automatic send_stored(input logic [7:0] b);
		if (b == START_BYTE || b == END_BYTE || b == ESCAPE_BYTE || $urandom_range(0, 9) == 0)
			send_byte(ESCAPE_BYTE);
		send_byte(b);
	endtask

	task automatic send_frame(input logic [7:0] payload[$], input bit with_crc, input bit corrupt);
		logic [15:0] c;
		c = CRC_INIT;
		foreach (payload[i])
			c = crc16_ccitt_byte(c, payload[i]);
		if (corrupt)
			c = c ^ (16'h0001 << $urandom_range(0, 15));
		send_byte(START_BYTE);
		send_byte(START_BYTE);
		foreach (payload[i])
			send_stored(payload[i]);
		if (with_crc) begin
			send_stored(c[15:8]);
			send_stored(c[7:0]);
		end
		send_byte(END_BYTE);
	endtask

	// line noise that never leaves a lone start byte behind
	task automatic send_noise(input int n);
		logic [7:0] b;
		repeat (n) begin
			b = 8'($urandom);
			send_byte(b);
			if (b == START_BYTE) begin
				b = 8'($urandom_range(0, 254));
				if (b >= START_BYTE)
					b++;
				send_byte(b);
			end
		end
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		int      gap;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (results_seen == HOLD_AT) begin
				m_tready <= 1'b0;
				repeat (HOLD_OFF) @(posedge clk);
			end
			gap = $urandom_range(0, recv_idle_max);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			results_seen++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic [7:0] payload[$];
		int         frames;
		int         pick;
		int         len;
		status_t    last_err;

		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= 8'h00;
		send_idle_max = 2;
		recv_idle_max = 2;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// hunt noise, second hunt byte not a start byte
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(START_BYTE);
		send_byte(8'h33);
		// empty frame, two-byte frame, short frame with checksum
		payload = {};
		send_frame(payload, 1'b0, 1'b0);
		payload = {START_BYTE, 8'hFF};
		send_frame(payload, 1'b0, 1'b0);
		payload = {8'h00, 8'hFF, END_BYTE, ESCAPE_BYTE, 8'h80};
		send_frame(payload, 1'b1, 1'b0);
		drain_results();

		frames = 0;
		while (frame_bytes < ITEMS) begin
			if (frames % 25 == 0) begin
				pick = $urandom_range(0, 2);
				send_idle_max = pick == 0 ? 0 : (pick == 1 ? 3 : 16);
				pick = $urandom_range(0, 2);
				recv_idle_max = pick == 0 ? 0 : (pick == 1 ? 3 : 16);
			end
			if (frames == 60)
				drain_results();
			pick = frames == 30 ? 99 : $urandom_range(0, 99);
			payload = {};
			if (pick < 8) begin
				send_noise($urandom_range(1, 6));
			end else if (pick < 12) begin
				repeat (2) payload.push_back(rand_frame_byte());
				send_frame(payload, 1'b0, 1'b0);
			end else if (pick < 15) begin
				send_frame(payload, 1'b0, 1'b0);
			end else begin
				if (frames == 30)
					len = BUFFER_BYTES - 2;
				else if ($urandom_range(0, 9) == 0)
					len = $urandom_range(17, 64);
				else
					len = $urandom_range(1, 16);
				repeat (len) payload.push_back(rand_frame_byte());
				send_frame(payload, 1'b1, 1'b0);
			end
			frames++;
		end
		drain_results();

		// any error halts the block for good, so only one per run
		last_err = status_t'($urandom_range(ST_BAD_CRC, ST_TOO_SHORT));
		payload = {};
		case (last_err)
		ST_BAD_CRC: begin
			repeat ($urandom_range(1, 8)) payload.push_back(rand_frame_byte());
			send_frame(payload, 1'b1, 1'b1);
		end
		ST_TOO_SHORT: begin
			payload.push_back(rand_frame_byte());
			send_frame(payload, 1'b0, 1'b0);
		end
		ST_UNEXPECTED_START: begin
			send_byte(START_BYTE);
			send_byte(START_BYTE);
			repeat ($urandom_range(0, 3)) send_stored(rand_frame_byte());
			send_byte(START_BYTE);
		end
		default: begin
			send_byte(START_BYTE);
			send_byte(START_BYTE);
			repeat (BUFFER_BYTES + 1) send_stored(8'($urandom));
		end
		endcase
		// halted: a full frame must give nothing
		send_byte(START_BYTE);
		send_byte(START_BYTE);
		send_byte(8'h41);
		send_byte(END_BYTE);
		send_noise(8);
		drain_results();
		repeat (20) @(posedge clk);

		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// File: filelist.f
rtl/sfrc_pkg.sv
rtl/stuffed_frame_receiver_crc16.sv
verif/sfrc_frame_checker.sv
verif/tb_stuffed_frame_receiver_crc16.sv
